// File: rtl/core/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg
// Shared widths and the segment command type for the tour length accumulator.
// ----------------------------------------------------------------------------
package tla_pkg;

    localparam int COORD_BITS = 16;                 // coordinate width, 8..24
    localparam int SQ_BITS    = 2 * COORD_BITS + 1; // dx*dx + dy*dy
    localparam int ROOT_BITS  = COORD_BITS + 1;     // floor sqrt of SQ_BITS
    localparam int VAL_BITS   = 2 * ROOT_BITS;      // radicand padded to digit pairs
    localparam int REM_BITS   = ROOT_BITS + 2;      // partial remainder
    localparam int CNT_BITS   = $clog2(ROOT_BITS);
    localparam int SUM_BITS   = 32;

    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                  has_seg;  // add a segment before closing
        logic                  last;     // close the route after this command
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
    } t_seg_cmd;

endpackage

// File: rtl/core/tla_front.sv
// ----------------------------------------------------------------------------
// tla_front
// Accepts route points, keeps the previous point, forms |dx| and |dy|.
// ----------------------------------------------------------------------------
module tla_front
    import tla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic                  i_last_point,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output t_seg_cmd              o_cmd
);

    logic                  r_have_prev;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic                  w_accept;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;

    always_comb begin
        o_cmd.has_seg = r_have_prev;
        o_cmd.last    = i_last_point;
        o_cmd.dx      = (i_x_coord >= r_prev_x) ? (i_x_coord - r_prev_x)
                                                : (r_prev_x - i_x_coord);
        o_cmd.dy      = (i_y_coord >= r_prev_y) ? (i_y_coord - r_prev_y)
                                                : (r_prev_y - i_y_coord);
    end

    // first point of a route that is not also its last needs no work downstream
    assign o_cmd_push = w_accept && (r_have_prev || i_last_point);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (w_accept) begin
            r_have_prev <= !i_last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_x <= i_x_coord;
            r_prev_y <= i_y_coord;
        end
    end

endmodule

// File: rtl/core/tla_queue.sv
// ----------------------------------------------------------------------------
// tla_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tla_queue
    import tla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_seg_cmd i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_seg_cmd o_data
);

    t_seg_cmd               r_mem [QDEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count;
    logic                   w_do_push;
    logic                   w_do_pop;

    assign o_full    = (r_count == QCNT_BITS'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QDEPTH))
        else $error("queue count beyond depth");

    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> !o_empty)
        else $error("pushed entry not visible");

endmodule

// File: rtl/core/tla_back.sv
// ----------------------------------------------------------------------------
// tla_back
// Squares, restoring floor square root, saturating sum and result register.
// ----------------------------------------------------------------------------
module tla_back
    import tla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_seg_cmd            i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [SUM_BITS-1:0] o_route_length
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic [2:0]                r_state;
    logic                      r_last;
    logic [COORD_BITS-1:0]     r_dx;
    logic [COORD_BITS-1:0]     r_dy;
    logic [2*COORD_BITS-1:0]   r_sqx;
    logic [2*COORD_BITS-1:0]   r_sqy;
    logic [VAL_BITS-1:0]       r_val;
    logic [REM_BITS-1:0]       r_rem;
    logic [ROOT_BITS-1:0]      r_root;
    logic [CNT_BITS-1:0]       r_cnt;
    logic [ROOT_BITS-1:0]      r_seg;
    logic [SUM_BITS-1:0]       r_sum;
    logic [SUM_BITS-1:0]       r_res;
    logic                      r_res_valid;

    logic [REM_BITS-1:0]       n_rem_shift;
    logic [REM_BITS-1:0]       n_trial;
    logic                      n_fits;
    logic [REM_BITS-1:0]       n_rem;
    logic [ROOT_BITS-1:0]      n_root;
    logic [SUM_BITS:0]         n_wide_sum;
    logic [SUM_BITS-1:0]       n_sum;

    // one result digit per cycle
    always_comb begin
        n_rem_shift = {r_rem[REM_BITS-3:0], r_val[VAL_BITS-1 -: 2]};
        n_trial     = {r_root[REM_BITS-3:0], 2'b01};
        n_fits      = (n_rem_shift >= n_trial);
        n_rem       = n_fits ? (n_rem_shift - n_trial) : n_rem_shift;
        n_root      = {r_root[ROOT_BITS-2:0], n_fits};
    end

    always_comb begin
        n_wide_sum = {1'b0, r_sum} + (SUM_BITS+1)'(r_seg);
        n_sum      = n_wide_sum[SUM_BITS] ? {SUM_BITS{1'b1}} : n_wide_sum[SUM_BITS-1:0];
    end

    assign o_cmd_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_empty        = !r_res_valid;
    assign o_route_length = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_pop) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= i_cmd.has_seg ? ST_MUL : ST_ACC;
                    end
                end
                ST_MUL:  r_state <= ST_ADD;
                ST_ADD:  r_state <= ST_ROOT;
                ST_ROOT: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (!r_last) begin
                        r_sum   <= n_sum;
                        r_state <= ST_IDLE;
                    end else if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        r_sum       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    r_last <= i_cmd.last;
                    r_dx   <= i_cmd.dx;
                    r_dy   <= i_cmd.dy;
                    r_seg  <= '0;
                end
            end
            ST_MUL: begin
                r_sqx <= r_dx * r_dx;
                r_sqy <= r_dy * r_dy;
            end
            ST_ADD: begin
                r_val  <= VAL_BITS'({1'b0, r_sqx} + {1'b0, r_sqy});
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_BITS'(ROOT_BITS - 1);
            end
            ST_ROOT: begin
                r_val  <= {r_val[VAL_BITS-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_seg <= n_root;
                end
            end
            ST_ACC: begin
                if (r_last && !r_res_valid) begin
                    r_res <= n_sum;
                end
            end
            default: ;
        endcase
    end

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_pop) |=> (r_res_valid && $stable(r_res)))
        else $error("waiting result lost or changed");

    a_route_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && r_last && !r_res_valid)
        |=> (r_res_valid && r_sum == '0 && r_state == ST_IDLE))
        else $error("route close did not post result and clear sum");

endmodule

// File: rtl/core/tour_length_accumulator_top.sv
// ----------------------------------------------------------------------------
// tour_length_accumulator_top
// Euclidean tour length: sums floor distances between consecutive points.
// ----------------------------------------------------------------------------
// Usage
//   Input queue side: drive i_x_coord, i_y_coord, i_last_point with push high;
//   a transfer happens on a rising edge with push high and full low.
//   Result queue side: while empty is low, o_route_length holds the total of
//   the oldest finished route; a transfer happens on an edge with pop high
//   and empty low. One result per route, posted after the point marked last.
// Timing
//   The first point of a route only loads the previous-point registers.
//   Every later point passes through the back end in order: issue, the two
//   squares, their sum, the restoring square root (one root bit per cycle)
//   and the accumulate step; the next command is taken only after that.
//   The root iteration sets the sustained rate. A four-entry command queue
//   lets the front keep accepting points while the back end works.
//   A single-point route goes from issue straight to the accumulate step.
// Reset and stall
//   Synchronous active-low reset empties the queue, drops any route in
//   progress and any waiting result. If the receiver stalls, the finished
//   total waits in the result register; the next route keeps accumulating
//   and only its close waits. full rises once the queue fills behind it.
// ----------------------------------------------------------------------------
module tour_length_accumulator_top
    import tla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic                  i_last_point,
    output logic                  empty,
    input  logic                  pop,
    output logic [SUM_BITS-1:0]   o_route_length
);

    logic     w_q_full;
    logic     w_q_empty;
    logic     w_cmd_push;
    logic     w_cmd_pop;
    t_seg_cmd w_cmd_in;
    t_seg_cmd w_cmd_out;

    // front: point intake and deltas
    tla_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_last_point (i_last_point),
        .i_q_full     (w_q_full),
        .o_full       (full),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in)
    );

    // decoupling queue
    tla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_cmd_out)
    );

    // back: square root and accumulation
    tla_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!w_q_empty),
        .i_cmd          (w_cmd_out),
        .o_cmd_pop      (w_cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_route_length (o_route_length)
    );

endmodule

// File: tb/sv/tour_length_accumulator_top_test.sv
// ----------------------------------------------------------------------------
// tour_length_accumulator_top_test
// Self-checking test of the tour length accumulator.
//
// Route points go in through the input queue side and route totals come
// back on the result queue side. A local model of the block tracks the
// previous point and the running sum. It predicts one total per route, and
// each popped total is checked against the oldest prediction. The test runs
// directed routes, one long route of full-span segments, a pause that
// lets every result drain, and a long stretch of random routes. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module tour_length_accumulator_top_test
    import tla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int          RANDOM_POINTS = 1300;
    // Full diagonal segments, each floor(65535 * sqrt(2)) = 92680
    localparam int          LONG_SEGMENTS = 200;
    localparam int          DRAIN_CYCLES  = 120;   // > back end latency plus queue
    localparam int          MAX_PRINTED   = 100;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [COORD_BITS-1:0] i_x_coord;
    logic [COORD_BITS-1:0] i_y_coord;
    logic                  i_last_point;
    logic                  empty;
    logic                  pop;
    logic [SUM_BITS-1:0]   o_route_length;

    tour_length_accumulator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_last_point   (i_last_point),
        .empty          (empty),
        .pop            (pop),
        .o_route_length (o_route_length)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model state: previous point, running sum, and the totals of closed
    // routes still waiting to be popped (oldest first).
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    logic                  route_open;
    logic [SUM_BITS-1:0]   route_sum;
    logic [SUM_BITS-1:0]   route_lengths_due[$];

    int unsigned error_count = 0;

    // Idle knobs, flipped by the tests to get stretches with and without gaps
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    // ------------------------------------------------------------------
    // Mismatch reporting: one line each, printing capped, always counted
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (error_count < MAX_PRINTED)
            $display("tb: mismatch at %0t: %s, expected %0d, got %0d",
                     $realtime, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Integer floor square root, settled one root bit at a time from the top
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic void model_route_point(input logic [COORD_BITS-1:0] x,
                                              input logic [COORD_BITS-1:0] y,
                                              input logic last);
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [63:0]           sq;
        logic [63:0]           total;
        if (route_open) begin
            dx    = (x >= last_x) ? x - last_x : last_x - x;
            dy    = (y >= last_y) ? y - last_y : last_y - y;
            sq    = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
            total = 64'(route_sum) + floor_root(sq);
            // sum saturates and stays pinned until the route closes
            route_sum = (total > 64'hFFFF_FFFF) ? '1 : total[SUM_BITS-1:0];
        end
        last_x     = x;
        last_y     = y;
        route_open = 1'b1;
        if (last) begin
            route_lengths_due = {route_lengths_due, route_sum};
            route_open = 1'b0;
            route_sum  = '0;
            last_x     = '0;
            last_y     = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: a transfer on the result side happens at a rising
    // edge with pop high and empty low; compare with the oldest total.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        logic [SUM_BITS-1:0] want;
        if (i_rst_n && pop && !empty) begin
            if (route_lengths_due.size() == 0) begin
                report_mismatch("result with no route closed", 0, o_route_length);
            end else begin
                want = route_lengths_due.pop_front();
                if (o_route_length !== want)
                    report_mismatch("route_length", want, o_route_length);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pop driven at the falling edge. Stalls are mostly short
    // with a few long ones, and can be switched off for a stretch.
    // ------------------------------------------------------------------
    initial begin : drive_pop
        int unsigned stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 30) begin
                    if ($urandom_range(0, 99) < 88)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(20, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(15, 60);
    endfunction

    // Drive one route point and hold it until the input side takes it. The
    // point is fed to the model on the edge where the transfer happens.
    task automatic push_point(input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y,
                              input logic last);
        int unsigned gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push         <= 1'b1;
        i_x_coord    <= x;
        i_y_coord    <= y;
        i_last_point <= last;
        do
            @(posedge i_clk);
        while (full);
        model_route_point(x, y, last);
    endtask

    // Sender holds off until every predicted total has been popped
    task automatic wait_all_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (route_lengths_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Coordinate picker: full range, near the previous point, the corners,
    // or close to zero
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] prev);
        int          v;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return COORD_BITS'($urandom_range(0, COORD_MAX));
        if (mode < 7) begin
            v = int'(prev) + int'($urandom_range(0, 512)) - 256;
            if (v < 0)
                v = 0;
            if (v > COORD_MAX)
                v = COORD_MAX;
            return COORD_BITS'(v);
        end
        if (mode < 8)
            return ($urandom_range(0, 1) != 0) ? COORD_BITS'(COORD_MAX) : '0;
        return COORD_BITS'($urandom_range(0, 15));
    endfunction

    function automatic int unsigned pick_route_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 1;
        else if (r < 88)
            return $urandom_range(2, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners, single-point routes, zero-length segments, both signs of
    // the coordinate difference
    task automatic test_directed_routes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // single-point routes, back to back: each closes at 0
        push_point(16'd0, 16'd0, 1'b1);
        push_point(16'hFFFF, 16'hFFFF, 1'b1);
        // full diagonal, the largest segment
        push_point(16'd0, 16'd0, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 1'b1);
        // diagonal going down in x, then a pure y segment
        push_point(16'hFFFF, 16'd0, 1'b0);
        push_point(16'd0, 16'hFFFF, 1'b0);
        push_point(16'd0, 16'd0, 1'b1);
        // 3-4-5 there and back
        push_point(16'd3, 16'd4, 1'b0);
        push_point(16'd0, 16'd0, 1'b0);
        push_point(16'd3, 16'd4, 1'b1);
        // repeated point: zero-length segment
        push_point(16'd100, 16'd100, 1'b0);
        push_point(16'd100, 16'd100, 1'b1);
        // anti-diagonal
        push_point(16'd0, 16'hFFFF, 1'b0);
        push_point(16'hFFFF, 16'd0, 1'b1);
        // tiny step, floor of sqrt(2)
        push_point(16'd12345, 16'd54321, 1'b0);
        push_point(16'd12346, 16'd54320, 1'b1);
        // pure x at full span
        push_point(16'hFFFF, 16'd0, 1'b0);
        push_point(16'd0, 16'd0, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 1'b1);
        wait_all_results();
    endtask

    // One long route bouncing between opposite corners with no input gaps,
    // so the sum grows large while the back end runs flat out.
    task automatic test_long_route();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        push_point(16'd0, 16'd0, 1'b0);
        for (int k = 0; k < LONG_SEGMENTS; k++) begin
            if (k % 2 == 0)
                push_point(16'hFFFF, 16'hFFFF, 1'b0);
            else
                push_point(16'd0, 16'd0, 1'b0);
        end
        push_point(16'd5, 16'd7, 1'b0);
        push_point(16'd5, 16'd7, 1'b1);
        // a short route right after checks the sum was cleared
        push_point(16'd0, 16'd0, 1'b0);
        push_point(16'd6, 16'd8, 1'b1);
        tx_idle_on = 1'b1;
        wait_all_results();
    endtask

    // Several routes back to back with random receiver stalls, so closes can
    // wait behind the result register; then the sender pauses until all drain.
    task automatic test_pause_until_drained();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int unsigned           len;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        for (int r = 0; r < 6; r++) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                x = COORD_BITS'($urandom_range(0, COORD_MAX));
                y = COORD_BITS'($urandom_range(0, COORD_MAX));
                push_point(x, y, k == len - 1);
            end
        end
        wait_all_results();
        tx_idle_on = 1'b1;
    endtask

    // Random routes with mixed coordinate styles; idling on each side is
    // switched on and off in stretches
    task automatic test_random_routes();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        int unsigned           len;
        int unsigned           points_sent;
        int unsigned           routes_sent;
        points_sent = 0;
        routes_sent = 0;
        px = '0;
        py = '0;
        while (points_sent < RANDOM_POINTS) begin
            if (routes_sent % 30 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            len = pick_route_len();
            for (int k = 0; k < len; k++) begin
                x = pick_coord(px);
                y = pick_coord(py);
                push_point(x, y, k == len - 1);
                px = x;
                py = y;
                points_sent++;
            end
            routes_sent++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_x_coord    = '0;
        i_y_coord    = '0;
        i_last_point = 1'b0;
        route_open   = 1'b0;
        route_sum    = '0;
        last_x       = '0;
        last_y       = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_routes();
        test_long_route();
        test_pause_until_drained();
        test_random_routes();

        // all points sent: wait for the last totals, then let the back end
        // settle so any stray result shows up
        @(negedge i_clk);
        push <= 1'b0;
        while (route_lengths_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: many times the slowest legal run (every point with the
    // longest gap, a full root and a long receiver stall)
    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: tour_length_accumulator_top.f
rtl/core/tla_pkg.sv
rtl/core/tla_front.sv
rtl/core/tla_queue.sv
rtl/core/tla_back.sv
rtl/core/tour_length_accumulator_top.sv
tb/sv/tour_length_accumulator_top_test.sv
